// File: rtl/core/trsort_pkg.sv
// trsort_pkg: shared types, constants and state codes of the tcp record sorter
// no dependencies
`timescale 1ns / 1ps

package trsort_pkg;

   localparam int unsigned DEPTH_DEFAULT = 64;
   localparam logic [31:0] WINDOW_RESET = 32'd2000;
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic {
      ACT_LOAD   = 1'b0,
      ACT_FINISH = 1'b1
   } action_type;

   typedef struct packed {
      logic        action;
      logic [31:0] seq_number;
      logic [31:0] ack_number;
      logic [15:0] payload_length;
      logic        fin_bit;
      logic [31:0] record_tag;
   } req_type;

   typedef struct packed {
      logic [31:0] out_seq;
      logic [31:0] out_ack;
      logic [15:0] out_length;
      logic        out_fin;
      logic [31:0] out_tag;
      logic        ack_mode;
      logic        dropped;
      logic        last_record;
   } rsp_type;

   // record as held in the store
   typedef struct packed {
      logic [31:0] seq;
      logic [31:0] ack;
      logic [15:0] len;
      logic        fin;
      logic [31:0] tag;
   } rec_type;

   // command passed from front to back
   typedef struct packed {
      logic    finish;
      rec_type rec;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MODE_RD,
      ST_MODE_CHK,
      ST_KEY_RD,
      ST_KEY_WAIT,
      ST_CMP_RD,
      ST_CMP_WAIT,
      ST_CMP,
      ST_PLACE,
      ST_EMIT_RD,
      ST_EMIT_WAIT,
      ST_EMIT
   } state_type;

endpackage

// File: rtl/core/tcp_record_insertion_sort.sv
// tcp_record_insertion_sort: top level, window register and front/back wiring
// depends on trsort_pkg, trsort_front, trsort_back
`timescale 1ns / 1ps

// Loads one record word per cycle, while the back end is idle, into a DEPTH-entry
// store through a two-entry queue; a finish word sorts the loaded records in
// place by insertion sort and streams them out in order. A finish first runs the
// mode test, then for each record after the first reads the key and makes one
// comparison per shift, and one more when the walk stops above the bottom, then
// emits each record, holding while the output stalls; every store read is
// registered. key_window must be written by the user only while the block is
// idle; the block itself does not enforce it.

module tcp_record_insertion_sort
   import trsort_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   logic [31:0] window_ff;
   logic        cmd_valid, cmd_ready, busy;
   cmd_type     cmd_data;

   // window register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (csr_valid) begin
         window_ff <= csr_data;
      end
   end

   trsort_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data)
   );

   trsort_back #(.DEPTH(DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd_data   (cmd_data),
      .key_window (window_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .busy       (busy)
   );

   // a word leaves the back only while it is busy
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response without busy back end");

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // the back takes a command only while idle
   a_cmd_take: assert property (@(posedge clock) disable iff (reset)
      cmd_ready |-> !busy) else $error("back took command while busy");

endmodule

// File: rtl/core/trsort_front.sv
// trsort_front: input stage and command queue between front and back
// depends on trsort_pkg
`timescale 1ns / 1ps

module trsort_front
   import trsort_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    cmd_valid,
   input  logic    cmd_ready,
   output cmd_type cmd_data
);

   localparam int unsigned PW = $clog2(QUEUE_DEPTH);

   cmd_type         queue_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]     fill_ff, fill_in;
   logic            push, pop;
   cmd_type         cmd_new;

   // classify the incoming word
   always_comb begin
      cmd_new.finish = (req_data.action == ACT_FINISH);
      cmd_new.rec.seq = req_data.seq_number;
      cmd_new.rec.ack = req_data.ack_number;
      cmd_new.rec.len = req_data.payload_length;
      cmd_new.rec.fin = req_data.fin_bit;
      cmd_new.rec.tag = req_data.record_tag;
   end

   assign req_ready = (fill_ff != (PW+1)'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign cmd_valid = (fill_ff != '0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd_data  = queue_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = push ? PW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? PW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      fill_in   = fill_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// File: rtl/core/trsort_back.sv
// trsort_back: record store, insertion sort sequencer and output register
// depends on trsort_pkg
`timescale 1ns / 1ps

module trsort_back
   import trsort_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd_data,
   input  logic [31:0] key_window,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   output logic        busy
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = AW + 1;

   rec_type       mem_ff [DEPTH];
   rec_type       rd_data_ff;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          over_ff, over_in;
   logic          mode_ff, mode_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [1:0]    mchk_ff, mchk_in;
   logic [31:0]   s5_ff, s5_in, s6_ff, s6_in;
   rec_type       key_ff, key_in;
   rsp_type       out_ff;
   logic          out_v_ff, out_v_in;

   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   rec_type       wr_data;
   logic          load_out;
   logic [31:0]   ck, kk, seq_m, diff;
   logic          shift;

   // mode test reads positions 5, 6, 7; unloaded ones read as zero
   assign seq_m = ({30'd0, mchk_ff} + 32'd5 < 32'(count_ff)) ? rd_data_ff.seq : 32'd0;

   // compare key against entry below
   always_comb begin
      ck    = mode_ff ? rd_data_ff.ack : rd_data_ff.seq;
      kk    = mode_ff ? key_ff.ack : key_ff.seq;
      diff  = ck - kk;
      shift = (ck >= kk) && (diff <= key_window);
      if (ck == kk) begin
         if (rd_data_ff.len < key_ff.len) shift = 1'b0;
         if (rd_data_ff.len == key_ff.len && rd_data_ff.fin < key_ff.fin) shift = 1'b0;
      end
   end

   assign cmd_ready = (state_ff == ST_IDLE) && !out_v_ff;
   assign busy      = (state_ff != ST_IDLE) || out_v_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd_ready && cmd_data.finish) begin
               state_in = (count_ff == '0) ? ST_IDLE : ST_MODE_RD;
            end
         end
         ST_MODE_RD:  state_in = ST_MODE_CHK;
         ST_MODE_CHK: begin
            if (mchk_ff == 2'd2) begin
               state_in = (count_ff > CW'(1)) ? ST_KEY_RD : ST_EMIT_RD;
            end else begin
               state_in = ST_MODE_RD;
            end
         end
         ST_KEY_RD:   state_in = ST_KEY_WAIT;
         ST_KEY_WAIT: state_in = ST_CMP_RD;
         ST_CMP_RD:   state_in = ST_CMP_WAIT;
         ST_CMP_WAIT: state_in = ST_CMP;
         ST_CMP: begin
            if (shift) state_in = (pos_ff == CW'(1)) ? ST_PLACE : ST_CMP_RD;
            else state_in = ST_PLACE;
         end
         ST_PLACE:    state_in = (i_ff + 1'b1 == count_ff) ? ST_EMIT_RD : ST_KEY_RD;
         ST_EMIT_RD:  state_in = ST_EMIT_WAIT;
         ST_EMIT_WAIT: state_in = ST_EMIT;
         ST_EMIT: begin
            if (!out_v_ff || rsp_ready) begin
               state_in = (i_ff + 1'b1 == count_ff) ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      count_in = count_ff;
      over_in  = over_ff;
      mode_in  = mode_ff;
      i_in     = i_ff;
      pos_in   = pos_ff;
      mchk_in  = mchk_ff;
      s5_in    = s5_ff;
      s6_in    = s6_ff;
      key_in   = key_ff;
      rd_en    = 1'b0;
      rd_addr  = '0;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = cmd_data.rec;
      load_out = 1'b0;
      out_v_in = out_v_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               if (!cmd_data.finish) begin
                  if (count_ff == CW'(DEPTH)) begin
                     over_in = 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[AW-1:0];
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  mchk_in = '0;
                  if (count_ff == '0) over_in = 1'b0;
               end
            end
         end
         ST_MODE_RD: begin
            rd_en   = 1'b1;
            rd_addr = AW'(mchk_ff + 3'd5);
         end
         ST_MODE_CHK: begin
            if (mchk_ff == 2'd0) s5_in = seq_m;
            if (mchk_ff == 2'd1) s6_in = seq_m;
            mchk_in = mchk_ff + 1'b1;
            if (mchk_ff == 2'd2) begin
               mode_in = (s5_ff == s6_ff) && (s5_ff == seq_m);
               i_in    = (count_ff > CW'(1)) ? CW'(1) : CW'(0);
            end
         end
         ST_KEY_RD: begin
            rd_en   = 1'b1;
            rd_addr = i_ff[AW-1:0];
            pos_in  = i_ff;
         end
         ST_KEY_WAIT: key_in = rd_data_ff;
         ST_CMP_RD: begin
            rd_en   = 1'b1;
            rd_addr = AW'(pos_ff - 1'b1);
         end
         ST_CMP: begin
            if (shift) begin
               wr_en   = 1'b1;
               wr_addr = pos_ff[AW-1:0];
               wr_data = rd_data_ff;
               pos_in  = pos_ff - 1'b1;
            end
         end
         ST_PLACE: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff[AW-1:0];
            wr_data = key_ff;
            i_in    = (i_ff + 1'b1 == count_ff) ? CW'(0) : CW'(i_ff + 1'b1);
         end
         ST_EMIT_RD: begin
            rd_en   = 1'b1;
            rd_addr = i_ff[AW-1:0];
         end
         ST_EMIT: begin
            if (!out_v_ff || rsp_ready) begin
               load_out = 1'b1;
               out_v_in = 1'b1;
               i_in     = i_ff + 1'b1;
               if (i_ff + 1'b1 == count_ff) begin
                  count_in = '0;
                  over_in  = 1'b0;
                  i_in     = '0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         over_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         i_ff     <= '0;
         mchk_ff  <= '0;
         mode_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         over_ff  <= over_in;
         out_v_ff <= out_v_in;
         i_ff     <= i_in;
         mchk_ff  <= mchk_in;
         mode_ff  <= mode_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      s5_ff  <= s5_in;
      s6_ff  <= s6_in;
      key_ff <= key_in;
      if (load_out) begin
         out_ff.out_seq     <= rd_data_ff.seq;
         out_ff.out_ack     <= rd_data_ff.ack;
         out_ff.out_length  <= rd_data_ff.len;
         out_ff.out_fin     <= rd_data_ff.fin;
         out_ff.out_tag     <= rd_data_ff.tag;
         out_ff.ack_mode    <= mode_ff;
         out_ff.dropped     <= over_ff;
         out_ff.last_record <= (i_ff + 1'b1 == count_ff);
      end
   end

   // record store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

// File: tb/tcp_record_insertion_sort_tb.sv
// tcp_record_insertion_sort_tb: self-checking bench for the tcp record sorter
// depends on trsort_pkg and tcp_record_insertion_sort
`timescale 1ns / 1ps

module tcp_record_insertion_sort_tb;
   import trsort_pkg::*;

   localparam int unsigned SLOTS = 64;
   localparam int unsigned WATCHDOG_LIMIT = 40000;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned SETTLE_CYCLES = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;

   // shadow of the sorter state
   rec_type     shadow_store [SLOTS];
   int unsigned shadow_count;
   logic        shadow_overflow;
   logic [31:0] shadow_window;

   rsp_type     sorted_words [$];
   int unsigned error_count = 0;
   int unsigned sent_items = 0;
   bit          quiet = 1'b0;
   int unsigned hold_asks = 0;
   int unsigned idle_cycles = 0;

   always #4 clock = ~clock;

   tcp_record_insertion_sort i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic [31:0] seq_or_zero(input int unsigned pos);
      if (pos < shadow_count) return shadow_store[pos].seq;
      return 32'd0;
   endfunction

   // sort the shadow batch and queue the words it emits
   function automatic void sort_batch();
      int unsigned n;
      int unsigned pos;
      logic        by_ack;
      rec_type     key;
      rec_type     cur;
      logic [31:0] kk;
      logic [31:0] ck;
      rsp_type     w;
      n = shadow_count;
      by_ack = (seq_or_zero(5) == seq_or_zero(6)) && (seq_or_zero(5) == seq_or_zero(7));
      for (int unsigned i = 1; i < n; i++) begin
         key = shadow_store[i];
         kk = by_ack ? key.ack : key.seq;
         pos = i;
         while (pos > 0) begin
            cur = shadow_store[pos-1];
            ck = by_ack ? cur.ack : cur.seq;
            if (ck < kk) break;
            if (ck - kk > shadow_window) break;
            if (ck == kk) begin
               if (cur.len < key.len) break;
               if (cur.len == key.len && cur.fin < key.fin) break;
            end
            shadow_store[pos] = cur;
            pos--;
         end
         shadow_store[pos] = key;
      end
      for (int unsigned k = 0; k < n; k++) begin
         w.out_seq = shadow_store[k].seq;
         w.out_ack = shadow_store[k].ack;
         w.out_length = shadow_store[k].len;
         w.out_fin = shadow_store[k].fin;
         w.out_tag = shadow_store[k].tag;
         w.ack_mode = by_ack;
         w.dropped = shadow_overflow;
         w.last_record = (k + 1 == n);
         sorted_words.push_back(w);
      end
      shadow_count = 0;
      shadow_overflow = 1'b0;
   endfunction

   function automatic void apply_word(input req_type item);
      if (item.action == ACT_FINISH) begin
         sort_batch();
      end else if (shadow_count >= SLOTS) begin
         shadow_overflow = 1'b1;
      end else begin
         shadow_store[shadow_count] = '{item.seq_number, item.ack_number,
                                       item.payload_length, item.fin_bit, item.record_tag};
         shadow_count++;
      end
   endfunction

   // send one word; called at a rising edge
   task automatic send_word(input req_type item);
      int unsigned gap;
      req_valid <= 1'b1;
      req_data <= item;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      apply_word(item);
      sent_items++;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_load(input logic [31:0] s, input logic [31:0] a,
                            input logic [15:0] l, input logic f, input logic [31:0] t);
      req_type item;
      item = '{ACT_LOAD, s, a, l, f, t};
      send_word(item);
   endtask

   task automatic send_finish();
      req_type item;
      item = '{ACT_FINISH, $urandom, $urandom, 16'($urandom), 1'($urandom), $urandom};
      send_word(item);
   endtask

   // wait until the sorter is idle, then write the window
   task automatic write_window(input logic [31:0] value);
      req_valid <= 1'b0;
      wait (sorted_words.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      shadow_window = value;
   endtask

   task automatic test_extremes();
      send_load(32'hFFFF_FFFF, 32'h0, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
      send_load(32'h0, 32'hFFFF_FFFF, 16'h0, 1'b0, 32'h0);
      send_load(32'd1500, 32'h8000_0000, 16'h8000, 1'b1, 32'hA5A5_5A5A);
      send_load(32'd3500, 32'h7FFF_FFFF, 16'h0001, 1'b0, 32'h5A5A_A5A5);
      send_finish();
   endtask

   // equal keys broken by length, then by fin
   task automatic test_equal_keys();
      send_load(32'd100, 32'd1, 16'd20, 1'b1, 32'd1);
      send_load(32'd100, 32'd2, 16'd10, 1'b0, 32'd2);
      send_load(32'd100, 32'd3, 16'd20, 1'b0, 32'd3);
      send_load(32'd100, 32'd4, 16'd10, 1'b1, 32'd4);
      send_finish();
   endtask

   // positions five to seven share seq, so ack is the key
   task automatic test_ack_mode();
      for (int i = 0; i < 8; i++)
         send_load((i >= 5) ? 32'd777 : 32'(i * 50), 32'(9000 - i * 700),
                   16'($urandom), 1'($urandom), 32'(i));
      send_finish();
   endtask

   // empty finish, then a short batch where unloaded slots read as zero
   task automatic test_short_batches();
      send_finish();
      send_load(32'd40, 32'd7, 16'd3, 1'b0, 32'd11);
      send_load(32'd30, 32'd9, 16'd3, 1'b0, 32'd12);
      send_finish();
   endtask

   task automatic random_batch(input int unsigned size);
      logic [31:0] base;
      logic [31:0] ack_base;
      int unsigned style;
      logic [31:0] s;
      logic [31:0] a;
      logic [15:0] l;
      base = $urandom;
      ack_base = $urandom;
      style = $urandom_range(0, 3);
      for (int unsigned i = 0; i < size; i++) begin
         case (style)
            0: begin
               s = $urandom;
               a = $urandom;
            end
            1: begin
               s = base + $urandom_range(0, 4000);
               a = ack_base + $urandom_range(0, 4000);
            end
            2: begin
               s = base;
               a = ack_base + $urandom_range(0, 3000);
            end
            default: begin
               s = base + $urandom_range(0, 3);
               a = ack_base + $urandom_range(0, 3);
            end
         endcase
         l = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
         send_load(s, a, l, 1'($urandom), $urandom);
      end
      send_finish();
   endtask

   task automatic random_size_batch();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) random_batch($urandom_range(1, 12));
      else if (pick < 9) random_batch($urandom_range(13, 30));
      else random_batch($urandom_range(60, 70));
   endtask

   task automatic test_overflow();
      random_batch(66);
   endtask

   // receiver holds off once the first batch emits while the next one is offered
   task automatic test_backpressure();
      hold_asks++;
      random_batch(40);
      random_batch(30);
   endtask

   task automatic test_random(input int unsigned target);
      int unsigned stop_at;
      stop_at = sent_items + target;
      while (sent_items < stop_at) random_size_batch();
   endtask

   // result side: random stalls plus requested long hold-off
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;
   int unsigned stall_left = 0;
   always @(posedge clock) begin
      if (hold_asks != hold_seen && rsp_valid) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (quiet) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 10);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare each accepted word with the oldest expected one
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (sorted_words.size() == 0) begin
            report("unexpected word", rsp_data.out_tag, 32'd0);
         end else begin
            want = sorted_words.pop_front();
            if (rsp_data.out_seq !== want.out_seq) report("out_seq", rsp_data.out_seq, want.out_seq);
            if (rsp_data.out_ack !== want.out_ack) report("out_ack", rsp_data.out_ack, want.out_ack);
            if (rsp_data.out_length !== want.out_length)
               report("out_length", 32'(rsp_data.out_length), 32'(want.out_length));
            if (rsp_data.out_fin !== want.out_fin)
               report("out_fin", 32'(rsp_data.out_fin), 32'(want.out_fin));
            if (rsp_data.out_tag !== want.out_tag) report("out_tag", rsp_data.out_tag, want.out_tag);
            if (rsp_data.ack_mode !== want.ack_mode)
               report("ack_mode", 32'(rsp_data.ack_mode), 32'(want.ack_mode));
            if (rsp_data.dropped !== want.dropped)
               report("dropped", 32'(rsp_data.dropped), 32'(want.dropped));
            if (rsp_data.last_record !== want.last_record)
               report("last_record", 32'(rsp_data.last_record), 32'(want.last_record));
         end
      end
   end

   // watchdog on cycles with no handshake anywhere
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("tcp_record_insertion_sort_tb: FAIL");
         $finish;
      end
   end

   initial begin
      shadow_count = 0;
      shadow_overflow = 1'b0;
      shadow_window = WINDOW_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_equal_keys();
      test_ack_mode();
      test_short_batches();
      test_overflow();
      test_backpressure();

      write_window(32'd0);
      test_random(60);
      write_window(32'hFFFF_FFFF);
      test_random(60);
      write_window(32'd1);
      test_random(50);
      write_window($urandom_range(100, 5000));
      test_random(50);

      // last stretch runs without any idling
      write_window(WINDOW_RESET);
      quiet = 1'b1;
      test_random(40);

      req_valid <= 1'b0;
      wait (sorted_words.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tcp_record_insertion_sort_tb: PASS");
      else
         $display("tcp_record_insertion_sort_tb: FAIL");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/trsort_pkg.sv
rtl/core/trsort_front.sv
rtl/core/trsort_back.sv
rtl/core/tcp_record_insertion_sort.sv
tb/tcp_record_insertion_sort_tb.sv
